// ----- src/pts_pkg.sv -----
// Shared types and constants of the process table scheduler.
package pts_pkg;
  localparam int SLOT_COUNT_DEF = 16;
  localparam logic [1:0] ST_DEAD  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_SLEEP = 2'd2;
  localparam logic [1:0] KIND_CREATE = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_SLEEP  = 2'd2;
  localparam logic [1:0] KIND_SCHED  = 2'd3;
  localparam logic [1:0] MODE_RR  = 2'd0;
  localparam logic [1:0] MODE_ML  = 2'd1;
  localparam logic [1:0] MODE_MLF = 2'd2;
  localparam logic signed [4:0] PRIO_MIN = -5'sd10;
  localparam logic signed [4:0] PRIO_MAX = 5'sd10;
  // One table entry: status, priority level, quantum and wake time.
  typedef struct packed {
    logic [1:0]        status;
    logic signed [4:0] level;
    logic [4:0]        quantum;
    logic [31:0]       wake;
  } entry_t;
  localparam int ENTRY_W = $bits(entry_t);
endpackage

// ----- src/pts_if.sv -----
// Valid/ready channel interfaces for items and results.
interface pts_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        kind;
  logic [3:0]        slot;
  logic signed [4:0] new_priority;
  logic [31:0]       sleep_seconds;
  logic [31:0]       now_seconds;
  modport source (output valid, kind, slot, new_priority, sleep_seconds, now_seconds,
                  input ready);
  modport sink (input valid, kind, slot, new_priority, sleep_seconds, now_seconds,
                output ready);
endinterface

interface pts_out_if;
  logic              valid;
  logic              ready;
  logic [3:0]        chosen_slot;
  logic [4:0]        chosen_quantum;
  logic signed [4:0] chosen_priority;
  logic              create_ok;
  logic [3:0]        created_slot;
  modport source (output valid, chosen_slot, chosen_quantum, chosen_priority, create_ok,
                  created_slot, input ready);
  modport sink (input valid, chosen_slot, chosen_quantum, chosen_priority, create_ok,
                created_slot, output ready);
endinterface

// ----- src/pts_ram.sv -----
// Generic single-port-write, one-read RAM with registered read data.
module pts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- src/process_table_scheduler.sv -----
// Process table scheduler: slot table in RAM, sweeping sequencer.
//
// Items come in on in_ch (kind, slot, new_priority, sleep_seconds,
// now_seconds); one result per item leaves on out_ch. policy_mode is
// written through cfg_we/cfg_wdata; the user must do this only while
// the block is idle, as the block itself does not enforce it. The slot
// table sits in one RAM, one entry per slot, with registered read data.
// Every item is handled by sweeps over the table, one entry per cycle,
// through the single RAM read port:
//   create, delete, sleep: one sweep, then the result is registered;
//   schedule: a wake sweep then a pick sweep, then the result is registered.
// The block takes one item at a time: after the result is taken it returns
// to idle before it accepts the next item.
// After reset a clearing pass writes every entry dead with zero fields;
// no item is accepted until it ends.
// The result is held in an output register; while the receiver stalls
// the block waits with the result and accepts nothing new.
module process_table_scheduler
  import pts_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_wdata,
  pts_in_if.sink     in_ch,
  pts_out_if.source  out_ch
);
  localparam int AW = $clog2(SLOT_COUNT);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] LAST = CW'(SLOT_COUNT - 1);
  localparam logic [CW-1:0] NSLOT = CW'(SLOT_COUNT);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_WAKE  = 3'd3;
  localparam logic [2:0] S_PICK  = 3'd4;
  localparam logic [2:0] S_FIX   = 3'd5;
  localparam logic [2:0] S_FIX2  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0] state;
  logic [1:0] policy_mode;
  logic [CW-1:0] rd_cnt;      // next address to read
  logic [CW-1:0] pipe_cnt;    // address of the entry arriving in rdata
  logic          pipe_v;
  logic [1:0]        kind;
  logic [3:0]        slot;
  logic signed [4:0] prio;
  logic [31:0]       dur;
  logic [31:0]       now;
  // Running best candidate of the pick sweep.
  logic          found;
  logic [AW-1:0] best;
  logic signed [4:0] best_prio;
  logic          best_after;  // best lies after the current slot
  entry_t        best_ent;
  entry_t        zero_ent;
  // Create search.
  logic          dead_found;
  logic [AW-1:0] dead_slot;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  logic [AW-1:0] raddr;
  entry_t        rdata;
  logic [ENTRY_W-1:0] rdata_raw;

  pts_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOT_COUNT)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);
  assign raddr = rd_cnt[AW-1:0];

  logic signed [4:0] clamp_prio;
  always_comb begin
    clamp_prio = prio;
    if (prio > PRIO_MAX) clamp_prio = PRIO_MAX;
    if (prio < PRIO_MIN) clamp_prio = PRIO_MIN;
  end

  // Whether the entry arriving now is after the current slot.
  logic cur_after;
  assign cur_after = int'(pipe_cnt) > int'(slot);

  // Candidate comparison for the pick sweep.
  logic is_run, better;
  assign is_run = pipe_v && rdata.status == ST_RUN;
  always_comb begin
    better = 1'b0;
    if (is_run) begin
      if (policy_mode == MODE_ML || policy_mode == MODE_MLF) begin
        if (!found) better = 1'b1;
        else if (rdata.level < best_prio) better = 1'b1;
        else if (rdata.level == best_prio && cur_after && !best_after) better = 1'b1;
      end else begin
        better = cur_after && !(found && best_after);
      end
    end
  end

  // Feedback update of the chosen entry.
  entry_t pick_ent, fb_ent;
  logic [AW-1:0] pick_slot;
  logic pick_valid;
  always_comb begin
    if (policy_mode == MODE_ML || policy_mode == MODE_MLF) pick_valid = found;
    else pick_valid = found && best_after;
    pick_slot = pick_valid ? best : '0;
    pick_ent  = pick_valid ? best_ent : zero_ent;
    fb_ent = pick_ent;
    if (pick_ent.level < PRIO_MAX) fb_ent.level = pick_ent.level + 5'sd1;
    fb_ent.quantum = 5'(fb_ent.level + 5'sd10);
  end

  assign in_ch.ready = state == S_IDLE;

  // Table writes, per state.
  always_comb begin
    we = 1'b0;
    waddr = pipe_cnt[AW-1:0];
    wdata = rdata;
    case (state)
      S_CLEAR: begin
        we = 1'b1;
        waddr = rd_cnt[AW-1:0];
        wdata = '0;
      end
      S_SWEEP: begin
        if (pipe_v && kind != KIND_CREATE && int'(slot) == int'(pipe_cnt)) begin
          we = 1'b1;
          if (kind == KIND_DELETE) wdata.status = ST_DEAD;
          else begin
            wdata.status = ST_SLEEP;
            wdata.wake = dur + now;
            if (policy_mode == MODE_MLF) begin
              wdata.level = PRIO_MIN;
              wdata.quantum = '0;
            end
          end
        end
      end
      S_WAKE: begin
        if (pipe_v && rdata.status == ST_SLEEP && now >= rdata.wake) begin
          we = 1'b1;
          wdata.status = ST_RUN;
        end
      end
      S_FIX: begin
        waddr = dead_slot;
        wdata = best_ent;
        if (kind == KIND_CREATE && dead_found) begin
          we = 1'b1;
          wdata.status = ST_RUN;
          wdata.level = (policy_mode == MODE_MLF) ? PRIO_MIN : clamp_prio;
          if (policy_mode == MODE_MLF) wdata.quantum = '0;
        end
      end
      S_FIX2: begin
        waddr = pick_slot;
        wdata = fb_ent;
        we = policy_mode == MODE_MLF;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      policy_mode <= MODE_RR;
      rd_cnt <= '0;
      pipe_v <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (cfg_we) policy_mode <= cfg_wdata;
      pipe_cnt <= rd_cnt;
      case (state)
        S_CLEAR: begin
          rd_cnt <= rd_cnt + 1'b1;
          if (rd_cnt == LAST) begin
            rd_cnt <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          pipe_v <= 1'b0;
          if (in_ch.valid) begin
            kind <= in_ch.kind;
            slot <= in_ch.slot;
            prio <= in_ch.new_priority;
            dur  <= in_ch.sleep_seconds;
            now  <= in_ch.now_seconds;
            rd_cnt <= '0;
            found <= 1'b0;
            best_after <= 1'b0;
            dead_found <= 1'b0;
            state <= (in_ch.kind == KIND_SCHED) ? S_WAKE : S_SWEEP;
          end
        end
        S_SWEEP, S_WAKE, S_PICK: begin
          rd_cnt <= (rd_cnt == NSLOT) ? rd_cnt : rd_cnt + 1'b1;
          pipe_v <= rd_cnt != NSLOT;
          if (state == S_SWEEP && pipe_v && rdata.status == ST_DEAD && !dead_found) begin
            dead_found <= 1'b1;
            dead_slot <= pipe_cnt[AW-1:0];
            best_ent <= rdata;
          end
          if (state == S_PICK) begin
            if (pipe_v && pipe_cnt == '0) begin
              zero_ent <= rdata;
            end
            if (better) begin
              found <= 1'b1;
              best <= pipe_cnt[AW-1:0];
              best_prio <= rdata.level;
              best_after <= cur_after;
              best_ent <= rdata;
            end
          end
          if (!pipe_v && rd_cnt == NSLOT) begin
            rd_cnt <= '0;
            if (state == S_WAKE) begin
              state <= S_PICK;
              pipe_v <= 1'b0;
            end else state <= (state == S_PICK) ? S_FIX2 : S_FIX;
          end
        end
        S_FIX: begin
          out_ch.valid <= 1'b1;
          out_ch.chosen_slot <= '0;
          out_ch.chosen_quantum <= '0;
          out_ch.chosen_priority <= '0;
          out_ch.create_ok <= kind == KIND_CREATE && dead_found;
          out_ch.created_slot <= (kind == KIND_CREATE && dead_found) ? 4'(dead_slot) : '0;
          state <= S_OUT;
        end
        S_FIX2: begin
          out_ch.valid <= 1'b1;
          out_ch.chosen_slot <= 4'(pick_slot);
          out_ch.chosen_quantum <= (policy_mode == MODE_MLF) ? fb_ent.quantum
                                                            : pick_ent.quantum;
          out_ch.chosen_priority <= (policy_mode == MODE_MLF) ? fb_ent.level
                                                             : pick_ent.level;
          out_ch.create_ok <= 1'b0;
          out_ch.created_slot <= '0;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is only offered while the sequencer waits in its output state.
  a_valid_state: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> state == S_OUT) else $error("result valid outside output state");
  // No item is taken while a result is pending.
  a_no_accept: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> !in_ch.ready) else $error("item accepted with pending result");
  // Schedule results never report a create.
  a_sched_flags: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) && kind == KIND_SCHED |-> !out_ch.create_ok)
    else $error("schedule result flagged as create");
endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the process table scheduler: directed, random and stall tests.
module testbench;
  import pts_pkg::*;

  localparam int NSLOT      = 16;
  localparam int DRAIN_WAIT = 60;
  localparam int STALL_LEN  = 400;
  localparam int WDOG_LIMIT = 4000;

  // One expected result of the block.
  typedef struct {
    logic [3:0]        slot;
    logic [4:0]        quantum;
    logic signed [4:0] prio;
    logic              ok;
    logic [3:0]        created;
  } sched_result_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [1:0] cfg_wdata;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  process_table_scheduler dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  // Shadow copy of the slot table and the policy register.
  logic [1:0]        tbl_status   [NSLOT];
  logic signed [4:0] tbl_priority [NSLOT];
  logic [4:0]        tbl_quantum  [NSLOT];
  logic [31:0]       tbl_wake     [NSLOT];
  logic [1:0]        policy;

  sched_result_t pending_results[$];
  int  mismatches;
  int  items_sent;
  int  results_seen;
  int  idle_cycles;
  bit  idling_on;
  bit  stall_request;
  int  sched_count;
  int  create_fails;
  logic [31:0] clock_now;

  always #5 clk = ~clk;

  // Round robin pick: upward from the slot after the current one, else slot 0.
  function automatic int pick_rr(int cur);
    for (int i = cur + 1; i < NSLOT; i++)
      if (tbl_status[i] == ST_RUN) return i;
    return 0;
  endfunction

  // Lowest level first, scanning circularly from the slot after the current one.
  function automatic int pick_level(int cur);
    for (int lvl = -10; lvl <= 10; lvl++)
      for (int k = 1; k <= NSLOT; k++) begin
        int i;
        i = (cur + k) % NSLOT;
        if (tbl_status[i] == ST_RUN && int'(tbl_priority[i]) == lvl) return i;
      end
    return 0;
  endfunction

  // Applies one accepted item to the shadow table and returns its result.
  function automatic sched_result_t apply_item(logic [1:0] kind, logic [3:0] slot,
                                               logic signed [4:0] prio, logic [31:0] dur,
                                               logic [31:0] now);
    sched_result_t r;
    int pick;
    int p;
    r = '{slot: '0, quantum: '0, prio: '0, ok: 1'b0, created: '0};
    case (kind)
      KIND_CREATE: begin
        pick = -1;
        for (int i = NSLOT - 1; i >= 0; i--)
          if (tbl_status[i] == ST_DEAD) pick = i;
        if (pick >= 0) begin
          p = int'(prio);
          if (p > 10) p = 10;
          if (p < -10) p = -10;
          tbl_priority[pick] = p[4:0];
          if (policy == MODE_MLF) begin
            tbl_priority[pick] = PRIO_MIN;
            tbl_quantum[pick]  = '0;
          end
          tbl_status[pick] = ST_RUN;
          r.ok      = 1'b1;
          r.created = pick[3:0];
        end else begin
          create_fails++;
        end
      end
      KIND_DELETE: tbl_status[slot] = ST_DEAD;
      KIND_SLEEP: begin
        tbl_status[slot] = ST_SLEEP;
        tbl_wake[slot]   = dur + now;
        if (policy == MODE_MLF) begin
          tbl_priority[slot] = PRIO_MIN;
          tbl_quantum[slot]  = '0;
        end
      end
      default: begin
        sched_count++;
        for (int i = 0; i < NSLOT; i++)
          if (tbl_status[i] == ST_SLEEP && now >= tbl_wake[i]) tbl_status[i] = ST_RUN;
        if (policy == MODE_ML) begin
          pick = pick_level(slot);
        end else if (policy == MODE_MLF) begin
          pick = pick_level(slot);
          p = int'(tbl_priority[pick]) + 1;
          if (p > 10) p = 10;
          tbl_priority[pick] = p[4:0];
          tbl_quantum[pick]  = 5'(p + 10);
        end else begin
          pick = pick_rr(slot);
        end
        r.slot     = pick[3:0];
        r.quantum  = tbl_quantum[pick];
        r.prio     = tbl_priority[pick];
      end
    endcase
    return r;
  endfunction

  // Sends one item; called at a falling edge, returns at a falling edge with valid high.
  task automatic send_item(logic [1:0] kind, logic [3:0] slot, logic signed [4:0] prio,
                           logic [31:0] dur, logic [31:0] now);
    int gap;
    if (idling_on && $urandom_range(3) == 0) begin
      gap = $urandom_range(19, 1);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.kind          <= kind;
    in_ch.slot          <= slot;
    in_ch.new_priority  <= prio;
    in_ch.sleep_seconds <= dur;
    in_ch.now_seconds   <= now;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(apply_item(kind, slot, prio, dur, now));
    items_sent++;
    @(negedge clk);
  endtask

  // Lowers valid; called at a falling edge, returns at the next one.
  task automatic release_input();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Writes the policy register once the block has gone idle.
  task automatic write_policy(logic [1:0] mode);
    release_input();
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(negedge clk);
    cfg_we <= 1'b0;
    policy = mode;
    @(negedge clk);
  endtask

  // One random item; mostly plausible traffic around a slowly advancing clock.
  task automatic send_random();
    int sel;
    logic [31:0] dur;
    logic [31:0] now;
    sel = $urandom_range(99);
    if ($urandom_range(15) == 0) clock_now = $urandom;
    else clock_now = clock_now + $urandom_range(6);
    now = clock_now;
    dur = ($urandom_range(9) == 0) ? $urandom : 32'($urandom_range(12));
    if (sel < 28)
      send_item(KIND_CREATE, 4'($urandom), 5'($urandom), $urandom, now);
    else if (sel < 42)
      send_item(KIND_DELETE, 4'($urandom), 5'($urandom), $urandom, now);
    else if (sel < 60)
      send_item(KIND_SLEEP, 4'($urandom), 5'($urandom), dur, now);
    else
      send_item(KIND_SCHED, 4'($urandom), 5'($urandom), $urandom, now);
  endtask

  // Extremes of the fields, every item kind and wrapping wake times.
  task automatic test_directed();
    send_item(KIND_CREATE, 4'd0, -5'sd16, 32'd0, 32'd0);
    send_item(KIND_CREATE, 4'd15, 5'sd15, 32'hFFFF_FFFF, 32'd0);
    send_item(KIND_CREATE, 4'd0, -5'sd10, 32'd0, 32'd0);
    send_item(KIND_CREATE, 4'd0, 5'sd10, 32'd0, 32'd0);
    send_item(KIND_SCHED, 4'd15, 5'sd0, 32'd0, 32'd0);
    send_item(KIND_SCHED, 4'd0, 5'sd0, 32'd0, 32'd0);
    send_item(KIND_SLEEP, 4'd1, 5'sd0, 32'hFFFF_FFFF, 32'd5);
    send_item(KIND_SLEEP, 4'd2, 5'sd0, 32'd0, 32'hFFFF_FFFF);
    send_item(KIND_SLEEP, 4'd9, 5'sd0, 32'd7, 32'd0);
    send_item(KIND_SCHED, 4'd1, 5'sd0, 32'd0, 32'd3);
    send_item(KIND_SCHED, 4'd1, 5'sd0, 32'd0, 32'd4);
    send_item(KIND_DELETE, 4'd0, 5'sd0, 32'd0, 32'd0);
    send_item(KIND_DELETE, 4'd15, 5'sd0, 32'd0, 32'd0);
    send_item(KIND_SCHED, 4'd3, 5'sd0, 32'd0, 32'hFFFF_FFFF);
    for (int i = 0; i < 9; i++)
      send_item(KIND_CREATE, 4'd0, 5'(i - 4), 32'd0, 32'd0);
  endtask

  // Random traffic under one policy setting.
  task automatic test_policy(logic [1:0] mode, int count);
    write_policy(mode);
    for (int i = 0; i < count; i++) send_random();
  endtask

  // Receiver holds off for a long time while items keep coming, then the sender pauses.
  task automatic test_backpressure();
    stall_request = 1'b1;
    for (int i = 0; i < 30; i++) send_random();
    release_input();
    while (pending_results.size() != 0) @(negedge clk);
    for (int i = 0; i < 30; i++) send_random();
  endtask

  // Receiver: random stall bursts, plus one long hold on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (stall_request) begin
        out_ch.ready <= 1'b0;
        repeat (STALL_LEN - 1) @(negedge clk);
        stall_request = 1'b0;
      end else if (idling_on && $urandom_range(5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(18)) @(negedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker against the oldest expectation.
  always @(posedge clk) begin
    sched_result_t e;
    if (!rst && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: slot %0d", out_ch.chosen_slot);
      end else begin
        e = pending_results.pop_front();
        if (out_ch.chosen_slot !== e.slot || out_ch.chosen_quantum !== e.quantum ||
            out_ch.chosen_priority !== e.prio || out_ch.create_ok !== e.ok ||
            out_ch.created_slot !== e.created) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Mismatch: exp slot %0d q %0d p %0d ok %0b c %0d, got %0d %0d %0d %0b %0d",
                     e.slot, e.quantum, e.prio, e.ok, e.created,
                     out_ch.chosen_slot, out_ch.chosen_quantum, out_ch.chosen_priority,
                     out_ch.create_ok, out_ch.created_slot);
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("Timeout with %0d results outstanding", pending_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = '0;
    in_ch.slot = '0;
    in_ch.new_priority = '0;
    in_ch.sleep_seconds = '0;
    in_ch.now_seconds = '0;
    mismatches = 0;
    items_sent = 0;
    results_seen = 0;
    idle_cycles = 0;
    sched_count = 0;
    create_fails = 0;
    stall_request = 1'b0;
    idling_on = 1'b1;
    clock_now = '0;
    policy = MODE_RR;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_status[i] = ST_DEAD;
      tbl_priority[i] = '0;
      tbl_quantum[i] = '0;
      tbl_wake[i] = '0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_policy(MODE_ML, 90);
    test_policy(MODE_MLF, 110);
    test_backpressure();
    test_policy(2'd3, 60);
    test_policy(MODE_RR, 90);
    test_policy(MODE_MLF, 80);
    idling_on = 1'b0;
    test_policy(MODE_ML, 80);

    release_input();
    wait_drained();
    $display("Covered %0d items (%0d schedules, %0d creates into a full table) over all",
             items_sent, sched_count, create_fails);
    $display("four policy codes, with random stalls and one long receiver hold.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
